FILE: rtl/pse_pkg.sv
// Package for the ping-pong snapshot engine.
// Holds the controller state type, request kind codes, field widths and the fill pattern.
// No dependencies.
package pse_pkg;

  localparam int KIND_W  = 2;
  localparam int PAGE_W  = 10;
  localparam int DATA_W  = 64;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0]  PIU_RESET    = 11'd1024;
  localparam logic [DATA_W-1:0] FILL_PATTERN = 64'h5353_5353_5353_5353;

  localparam logic [KIND_W-1:0] KIND_READ_LIVE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECKPOINT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ_SNAP  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_WALK,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

FILE: rtl/pingpong_snapshot_engine_top.sv
// Ping-pong snapshot engine, top level.
// Request channel in, result channel out, one write-only configuration register.
// Depends on pse_pkg, pse_ctrl and pse_store.
//
// Every accepted request gives exactly one result. kind selects read live page,
// write, checkpoint or read snapshot page; page_index addresses the page.
// Pages hold one FIELD_BITS word each, kept as a single row per page in one
// synchronous memory (live, odd and even copies, snapshot word, dirty marks).
// Requests are taken one at a time; in_stall is high while one is in progress.
// Reads and writes: the row is read on acceptance; in the access state the result
// is registered (or held under out_stall) and a write stores the modified row, so
// the next request waits for the read-then-write on the row memory.
// Checkpoint over n = min(pages_in_use, PAGES) pages: the result is registered
// once the walk is done; the walk reads one row a cycle and writes back the
// previous one when its dirty mark for the current set is set.
// After reset a clearing pass over all PAGES rows fills the memory while in_stall
// stays high; configuration writes are taken throughout.
// A result waiting under out_stall does not block the next request; a further
// finished result is held inside until the output register frees.
module pingpong_snapshot_engine_top #(
  parameter int PAGES      = 1024,
  parameter int FIELD_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pse_pkg::KIND_W-1:0] kind,
  input  logic [pse_pkg::PAGE_W-1:0] page_index,
  input  logic [pse_pkg::DATA_W-1:0] data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pse_pkg::DATA_W-1:0] read_data,
  output logic                       set_bit,
  input  logic                       cfg_wr_en,
  input  logic [pse_pkg::CFG_W-1:0]  cfg_wr_data
);
  import pse_pkg::*;

  localparam int AW    = $clog2(PAGES);
  localparam int ROW_W = 4 * FIELD_BITS + 2;

  mem_cmd_t         cmd;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [ROW_W-1:0] wdata;
  logic [ROW_W-1:0] rdata;

  pse_ctrl #(
    .PAGES      (PAGES),
    .FIELD_BITS (FIELD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .page_index  (page_index),
    .data        (data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .set_bit     (set_bit),
    .cmd         (cmd),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata)
  );

  pse_store #(
    .DEPTH (PAGES),
    .ROW_W (ROW_W)
  ) u_store (
    .clk   (clk),
    .cmd   (cmd),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: rtl/pse_store.sv
// Page row memory: one write port, one read port, registered read data.
// Depends on pse_pkg for the command struct.
module pse_store #(
  parameter int DEPTH = 1024,
  parameter int ROW_W = 258
) (
  input  logic                     clk,
  input  pse_pkg::mem_cmd_t        cmd,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ROW_W-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ROW_W-1:0]         rdata
);
  import pse_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pse_ctrl.sv
// Request sequencer: clearing pass, read-modify-write of page rows, checkpoint walk.
// Depends on pse_pkg; drives one pse_store instance through the memory ports.
module pse_ctrl #(
  parameter int PAGES      = 1024,
  parameter int FIELD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pse_pkg::KIND_W-1:0]     kind,
  input  logic [pse_pkg::PAGE_W-1:0]     page_index,
  input  logic [pse_pkg::DATA_W-1:0]     data,
  input  logic                           cfg_wr_en,
  input  logic [pse_pkg::CFG_W-1:0]      cfg_wr_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pse_pkg::DATA_W-1:0]     read_data,
  output logic                           set_bit,
  output pse_pkg::mem_cmd_t              cmd,
  output logic [$clog2(PAGES)-1:0]       waddr,
  output logic [4*FIELD_BITS+1:0]        wdata,
  output logic [$clog2(PAGES)-1:0]       raddr,
  input  logic [4*FIELD_BITS+1:0]        rdata
);
  import pse_pkg::*;

  localparam int FB    = FIELD_BITS;
  localparam int AW    = $clog2(PAGES);
  localparam int CW    = AW + 1;
  localparam int CMPW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int ROW_W = 4 * FB + 2;
  // row layout: live | odd | even | snapshot | odd dirty | even dirty
  localparam int LIVE_LO = 0;
  localparam int ODD_LO  = FB;
  localparam int EVEN_LO = 2 * FB;
  localparam int SNAP_LO = 3 * FB;
  localparam int ODD_D   = 4 * FB;
  localparam int EVEN_D  = 4 * FB + 1;

  localparam logic [FB-1:0]   FILL    = FILL_PATTERN[FB-1:0];
  localparam logic [CMPW-1:0] PAGES_C = CMPW'(PAGES);

  state_t state, state_next;

  logic [CW-1:0]     cnt;
  logic [CW-1:0]     limit;
  logic              current_set;
  logic [CFG_W-1:0]  pages_in_use;
  logic [KIND_W-1:0] kind_q;
  logic              ok_q;
  logic [AW-1:0]     addr_q;
  logic [FB-1:0]     data_q;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;
  logic [FB-1:0]     out_data;
  logic [FB-1:0]     hold_data;

  logic              accept;
  logic [CMPW-1:0]   page_ext;
  logic [CMPW-1:0]   piu_ext;
  logic [CMPW-1:0]   lim_w;
  logic              page_ok;
  logic [AW-1:0]     page_addr;
  logic              clear_last;
  logic              walk_more;
  logic              walk_dirty;
  logic              hold_needed;
  logic              complete;
  logic              load;
  logic [FB-1:0]     res;
  logic [FB-1:0]     access_res;
  logic [ROW_W-1:0]  fill_row;
  logic [ROW_W-1:0]  wr_row;
  logic [ROW_W-1:0]  walk_row;

  assign accept      = in_valid && !in_stall;
  assign page_ext    = CMPW'(page_index);
  assign piu_ext     = CMPW'(pages_in_use);
  assign lim_w       = (piu_ext > PAGES_C) ? PAGES_C : piu_ext;
  assign page_ok     = page_ext < PAGES_C;
  assign page_addr   = page_ext[AW-1:0];
  assign clear_last  = cnt[AW-1:0] == AW'(PAGES - 1);
  assign walk_more   = cnt < limit;
  assign walk_dirty  = current_set ? rdata[EVEN_D] : rdata[ODD_D];
  assign hold_needed = out_valid && out_stall;

  always_comb begin
    fill_row                    = '0;
    fill_row[LIVE_LO +: FB]     = FILL;
    fill_row[ODD_LO  +: FB]     = FILL;
    fill_row[EVEN_LO +: FB]     = FILL;
    fill_row[SNAP_LO +: FB]     = FILL;
    fill_row[ODD_D]             = 1'b0;
    fill_row[EVEN_D]            = 1'b1;

    wr_row                      = rdata;
    wr_row[LIVE_LO +: FB]       = data_q;
    if (current_set) begin
      wr_row[EVEN_LO +: FB]     = data_q;
      wr_row[EVEN_D]            = 1'b1;
    end else begin
      wr_row[ODD_LO +: FB]      = data_q;
      wr_row[ODD_D]             = 1'b1;
    end

    walk_row                    = rdata;
    if (current_set) begin
      walk_row[SNAP_LO +: FB]   = rdata[EVEN_LO +: FB];
      walk_row[EVEN_LO +: FB]   = '0;
      walk_row[EVEN_D]          = 1'b0;
    end else begin
      walk_row[SNAP_LO +: FB]   = rdata[ODD_LO +: FB];
      walk_row[ODD_LO +: FB]    = '0;
      walk_row[ODD_D]           = 1'b0;
    end

    access_res = '0;
    if (ok_q) begin
      case (kind_q)
        KIND_READ_LIVE: access_res = rdata[LIVE_LO +: FB];
        KIND_READ_SNAP: access_res = rdata[SNAP_LO +: FB];
        default:        access_res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    raddr      = page_addr;
    waddr      = addr_q;
    wdata      = wr_row;
    complete   = 1'b0;
    res        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_en = 1'b1;
        waddr     = cnt[AW-1:0];
        wdata     = fill_row;
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.rd_en  = 1'b1;
          state_next = (kind == KIND_CHECKPOINT) ? ST_WALK : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.wr_en  = (kind_q == KIND_WRITE) && ok_q;
        complete   = 1'b1;
        res        = access_res;
        state_next = hold_needed ? ST_HOLD : ST_IDLE;
      end
      ST_WALK: begin
        raddr     = cnt[AW-1:0];
        cmd.rd_en = walk_more;
        waddr     = pend_addr;
        wdata     = walk_row;
        cmd.wr_en = pend_valid && walk_dirty;
        if (!walk_more && !pend_valid) begin
          complete   = 1'b1;
          state_next = hold_needed ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign load = (complete && !hold_needed) || (state == ST_HOLD && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      current_set  <= 1'b0;
      pages_in_use <= PIU_RESET;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pages_in_use <= cfg_wr_data;
      end
      if (state == ST_CLEAR || (state == ST_WALK && walk_more)) begin
        cnt <= cnt + 1'b1;
      end else if (accept) begin
        cnt <= '0;
      end
      if (accept && kind == KIND_CHECKPOINT) begin
        current_set <= !current_set;
      end
      pend_valid <= (state == ST_WALK) && walk_more;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      ok_q   <= page_ok;
      addr_q <= page_addr;
      data_q <= data[FB-1:0];
      limit  <= lim_w[CW-1:0];
    end
    pend_addr <= cnt[AW-1:0];
    if (complete && hold_needed) begin
      hold_data <= res;
    end
    if (load) begin
      out_data <= (state == ST_HOLD) ? hold_data : res;
      set_bit  <= current_set;
    end
  end

  assign read_data = DATA_W'(out_data);

endmodule

FILE: rtl/pse_checker.sv
// Port-level checks for the ping-pong snapshot engine, bound to the top level.
// Depends on pse_pkg for field widths.
module pse_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pse_pkg::DATA_W-1:0] read_data,
  input logic                       set_bit
);
  import pse_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(set_bit))
    else $error("result changed under stall");

  // one request in progress at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  // clearing pass blocks requests right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("request taken during clearing pass");

endmodule

bind pingpong_snapshot_engine_top pse_checker u_chk (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for pingpong_snapshot_engine_top: drives random and directed requests,
// predicts every result with a page-store model held in a small scoreboard class.
// Depends on pse_pkg and the engine RTL.
module testbench;
  import pse_pkg::*;

  localparam int PAGE_COUNT     = 1024;
  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASE_ITEMS    = 60;
  localparam int QUIET_PHASES   = 2;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 16;

  class snapshot_board;
    logic [DATA_W-1:0] live_word [PAGE_COUNT];
    logic [DATA_W-1:0] odd_word  [PAGE_COUNT];
    logic [DATA_W-1:0] even_word [PAGE_COUNT];
    logic [DATA_W-1:0] snap_word [PAGE_COUNT];
    bit                odd_mark  [PAGE_COUNT];
    bit                even_mark [PAGE_COUNT];
    bit                active_set;
    logic [CFG_W-1:0]  walk_len;
    logic [DATA_W-1:0] due_words [$];
    bit                due_set_bits [$];
    int unsigned       mismatches;

    function void clear();
      for (int i = 0; i < PAGE_COUNT; i++) begin
        live_word[i] = FILL_PATTERN;
        odd_word[i]  = FILL_PATTERN;
        even_word[i] = FILL_PATTERN;
        snap_word[i] = FILL_PATTERN;
        odd_mark[i]  = 1'b0;
        even_mark[i] = 1'b1;
      end
      active_set = 1'b0;
      walk_len   = PIU_RESET;
      mismatches = 0;
    endfunction

    function void set_walk(logic [CFG_W-1:0] v);
      walk_len = v;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // flip, then sweep the set the new bit selects
    function void run_checkpoint();
      int span;
      active_set = ~active_set;
      span = (walk_len > PAGE_COUNT) ? PAGE_COUNT : int'(walk_len);
      for (int i = 0; i < span; i++) begin
        if (active_set) begin
          if (even_mark[i]) begin
            snap_word[i] = even_word[i];
            even_word[i] = '0;
            even_mark[i] = 1'b0;
          end
        end else if (odd_mark[i]) begin
          snap_word[i] = odd_word[i];
          odd_word[i]  = '0;
          odd_mark[i]  = 1'b0;
        end
      end
    endfunction

    function void take_request(logic [KIND_W-1:0] k, logic [PAGE_W-1:0] p,
                               logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] word;
      word = '0;
      case (k)
        KIND_READ_LIVE: word = live_word[p];
        KIND_WRITE: begin
          live_word[p] = d;
          if (active_set) begin
            even_word[p] = d;
            even_mark[p] = 1'b1;
          end else begin
            odd_word[p] = d;
            odd_mark[p] = 1'b1;
          end
        end
        KIND_CHECKPOINT: run_checkpoint();
        default: word = snap_word[p];
      endcase
      due_words.push_back(word);
      due_set_bits.push_back(active_set);
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    task check_result(logic [DATA_W-1:0] got_word, logic got_set);
      logic [DATA_W-1:0] want_word;
      logic              want_set;
      if (due_words.size() == 0) begin
        report_mismatch("unrequested result", got_word, '0);
        return;
      end
      want_word = due_words.pop_front();
      want_set  = due_set_bits.pop_front();
      if (got_word !== want_word) report_mismatch("read_data", got_word, want_word);
      if (got_set !== want_set)
        report_mismatch("set_bit", DATA_W'(got_set), DATA_W'(want_set));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page_index;
  logic [DATA_W-1:0] data;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] read_data;
  logic              set_bit;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;

  snapshot_board board;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;

  pingpong_snapshot_engine_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .page_index  (page_index),
    .data        (data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .set_bit     (set_bit),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic [KIND_W-1:0] k, logic [PAGE_W-1:0] p,
                              logic [DATA_W-1:0] d);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    page_index <= p;
    data       <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_request(k, p, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_walk(logic [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_walk(v);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return KIND_READ_LIVE;
    if (r < 55) return KIND_WRITE;
    if (r < 68) return KIND_CHECKPOINT;
    return KIND_READ_SNAP;
  endfunction

  // mostly pages the walk covers, so snapshots actually move
  function automatic logic [PAGE_W-1:0] pick_page(int hot);
    if ($urandom_range(0, 4) == 0) return PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
    return PAGE_W'($urandom_range(0, hot));
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_walk();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return PAGE_COUNT;
    if (r == 3) return ($urandom_range(0, 1) == 0) ? 2047 : PAGE_COUNT + 1;
    return $urandom_range(2, 24);
  endfunction

  // result side: random stall bursts plus the long hold
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) board.check_result(read_data, set_bit);
      if (stall_left > 0) stall_left--;
      else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int phases;
    int walk;
    int hot;
    bit quiet;
    board = new;
    board.clear();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = 1'b0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    kind        <= KIND_READ_LIVE;
    page_index  <= '0;
    data        <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= PIU_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_walk(PIU_RESET);

    // directed: fill values, field extremes, every kind, set flips both ways
    send_request(KIND_READ_LIVE, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd1023, '1);
    send_request(KIND_WRITE, 10'd0, '1);
    send_request(KIND_WRITE, 10'd1023, '0);
    send_request(KIND_WRITE, 10'd5, 64'h8000_0000_0000_0001);
    send_request(KIND_WRITE, 10'd682, 64'h0123_4567_89ab_cdef);
    send_request(KIND_READ_LIVE, 10'd0, '0);
    send_request(KIND_READ_LIVE, 10'd1023, '0);
    send_request(KIND_CHECKPOINT, 10'd341, '0);
    send_request(KIND_READ_SNAP, 10'd0, '0);
    send_request(KIND_WRITE, 10'd0, 64'ha5a5_a5a5_5a5a_5a5a);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd1023, '0);
    send_request(KIND_READ_SNAP, 10'd5, '0);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd0, '0);
    drain();
    // zero-length walk still flips the set
    write_walk(11'd0);
    send_request(KIND_WRITE, 10'd2, 64'hdead_beef_0000_ffff);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd2, '0);
    drain();
    // oversize walk clamps to the page count
    write_walk(11'd2047);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd2, '0);
    drain();
    write_walk(11'd1);
    send_request(KIND_WRITE, 10'd1, 64'h1111_2222_3333_4444);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_CHECKPOINT, 10'd0, '0);
    send_request(KIND_READ_SNAP, 10'd1, '0);
    drain();

    phases = RANDOM_ITEMS / PHASE_ITEMS;
    for (int ph = 0; ph < phases; ph++) begin
      quiet = (ph >= phases - QUIET_PHASES);
      walk  = pick_walk();
      write_walk(CFG_W'(walk));
      hot = (walk + 2 > PAGE_COUNT - 1) ? PAGE_COUNT - 1 : walk + 2;
      tx_idle_on = !quiet && (ph % 5 != 2) && ($urandom_range(0, 2) != 0);
      rx_idle_on = !quiet && ($urandom_range(0, 2) != 0);
      if (ph % 5 == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_kind(), pick_page(hot), pick_data());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
